// ===== hdl/swm_pkg.sv =====
// Package for the sliding window mean block.
// Holds widths, reset values, the controller state type and the command and status structs.
// No dependencies.
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WIN_W = 7;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd10;
  localparam int WIN_LIMIT = 127;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIVIDE,
    ST_FINISH
  } swm_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } swm_status_t;

endpackage

// ===== hdl/swm_div.sv =====
// Restoring divider for the sliding window mean block, one quotient bit per cycle.
// Divides the magnitude of the running sum by the window length.
// Depends on swm_pkg.
module swm_div import swm_pkg::*; #(
  parameter int SUM_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WIN_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIN_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [WIN_W:0]   rem_sh;
  logic [WIN_W:0]   diff;

  assign rem_sh = {rem, quo[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[WIN_W]) begin
        rem <= diff[WIN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[WIN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign done     = ~busy;

endmodule

// ===== hdl/swm_datapath.sv =====
// Datapath of the sliding window mean block: history ring, running sum, divider and output register.
// Acts on commands from swm_ctrl and returns status to it.
// Depends on swm_pkg and swm_div.
module swm_datapath import swm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_cmd_t                      cmd,
  output swm_status_t                   status,
  input  logic                          clear,
  input  logic [WIN_W-1:0]              win,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic                          average_valid,
  input  logic                          average_ready
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] ring_rd;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [PTR_W-1:0]              pos;
  logic [PTR_W-1:0]              pos_next;
  logic [WIN_W-1:0]              fill;
  logic signed [SUM_W-1:0]       running_sum;
  logic signed [SUM_W-1:0]       running_sum_next;
  logic                          full;
  logic                          neg;
  logic [SUM_W-1:0]              magnitude;
  logic [SUM_W-1:0]              quotient;
  logic [SUM_W-1:0]              signed_q;
  logic                          div_done;

  assign full = (fill >= win);

  always_comb begin
    running_sum_next = running_sum + SUM_W'(sample_q);
    if (full) begin
      running_sum_next = running_sum_next - SUM_W'(ring_rd);
    end
    if (int'(pos) + 1 >= int'(win)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
      ring_rd  <= ring[pos];
    end
    if (cmd.update) begin
      ring[pos] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos         <= '0;
      fill        <= '0;
      running_sum <= '0;
    end else if (cmd.update) begin
      pos         <= pos_next;
      running_sum <= running_sum_next;
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= running_sum[SUM_W-1];
    end
  end

  assign magnitude = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  swm_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (magnitude),
    .divisor  (win),
    .quotient (quotient),
    .done     (div_done)
  );

  assign signed_q = neg ? (~quotient + 1'b1) : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (cmd.load_out) begin
      average_valid <= 1'b1;
    end else if (average_ready) begin
      average_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average <= signed_q[SAMPLE_BITS-1:0];
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = ~average_valid | average_ready;

endmodule

// ===== hdl/swm_ctrl.sv =====
// Controller of the sliding window mean block.
// Sequences accept, sum update, division and output load for one item at a time.
// Depends on swm_pkg.
module swm_ctrl import swm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  swm_status_t status,
  output swm_cmd_t    cmd
);

  swm_state_t state;
  swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sliding_window_mean_core.sv =====
// Sliding window mean: moving average of signed fixed-point samples over a programmable window.
// The block takes one item at a time: a new sample is accepted only after the previous average has
// been loaded into the result register, as the bit-serial divider works on one sum at a time.
// The result register frees the input side while an average waits to be taken.
// Reset and any write of the window length clear the running sum, fill count and position.
// Reset sets the window length to 10; the history ring itself is not cleared.
module sliding_window_mean_core import swm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic                          average_valid,
  input  logic                          average_ready
);

  localparam int WIN_CAP = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;

  logic [WIN_W-1:0] window_length;
  logic [WIN_W-1:0] win_eff;
  logic             cfg_write;
  swm_cmd_t         cmd;
  swm_status_t      status;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW) begin
      prdata = {(APB_DATA_W-WIN_W)'(0), window_length};
    end
  end

  always_comb begin
    if (window_length == '0) begin
      win_eff = WIN_W'(1);
    end else if (int'(window_length) > WIN_CAP) begin
      win_eff = WIN_W'(WIN_CAP);
    end else begin
      win_eff = window_length;
    end
  end

  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  swm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .clear         (cfg_write),
    .win           (win_eff),
    .sample        (sample),
    .average       (average),
    .average_valid (average_valid),
    .average_ready (average_ready)
  );

endmodule

// ===== tb/sv/swm_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sliding window mean block: tracks the window register and the sample history,
// predicts every average and compares it with the accepted results. Depends on swm_pkg.
module swm_checker import swm_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [APB_ADDR_W-1:0]                paddr,
  input  logic [APB_DATA_W-1:0]                pwdata,
  input  logic [APB_DATA_W-1:0]                prdata,
  input  logic signed [SAMPLE_BITS_DEF-1:0]    sample,
  input  logic                                 sample_valid,
  input  logic                                 sample_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0]    average,
  input  logic                                 average_valid,
  input  logic                                 average_ready,
  output int                                   mismatches,
  output int                                   pending
);

  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  logic [WIN_W-1:0] win_len;
  sample_t          ring [MAX_WINDOW_DEF];
  int unsigned      slot;
  int unsigned      filled;
  longint           sum_acc;
  sample_t          expected_averages [$];

  function automatic void clear_history();
    slot    = 0;
    filled  = 0;
    sum_acc = 0;
  endfunction

  function automatic sample_t next_average(input sample_t s);
    int unsigned w;
    int unsigned pos;
    w = (win_len == 0) ? 1 : (win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len;
    pos = slot % w;
    if (filled < w) begin
      sum_acc += longint'(s);
      filled++;
    end else begin
      sum_acc += longint'(s) - longint'(ring[pos]);
    end
    ring[pos] = s;
    slot = (pos + 1 >= w) ? 0 : pos + 1;
    return sample_t'(sum_acc / longint'(w));
  endfunction

  always @(posedge clk) begin : track
    sample_t want;
    if (rst) begin
      win_len = WINDOW_RESET;
      clear_history();
      expected_averages.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pready && paddr == WINDOW_ADDR) begin
        if (pwrite) begin
          win_len = pwdata[WIN_W-1:0];
          clear_history();
        end else if (prdata !== APB_DATA_W'(win_len)) begin
          $error("window_length mismatch: expected %0d, actual %0d", win_len, prdata);
          mismatches++;
        end
      end
      if (sample_valid && sample_ready) begin
        expected_averages.push_back(next_average(sample));
      end
      if (average_valid && average_ready) begin
        if (expected_averages.size() == 0) begin
          $error("average: no item expected, actual %0d", average);
          mismatches++;
        end else begin
          want = expected_averages.pop_front();
          if (average !== want) begin
            $error("average mismatch: expected %0d, actual %0d", want, average);
            mismatches++;
          end
        end
      end
    end
    pending = expected_averages.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the sliding window mean testbench: clock, reset, register accesses, sample stimulus and result draining.
// Depends on swm_pkg, sliding_window_mean_core and swm_checker.
module tb;
  import swm_pkg::*;

  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW, 2'b00};
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 100;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  sample_t               sample = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               average;
  logic                  average_valid;
  logic                  average_ready = 1'b0;

  int mismatches;
  int pending;
  int gap_max = 9;
  int quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_mean_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample(sample), .sample_valid(sample_valid), .sample_ready(sample_ready),
    .average(average), .average_valid(average_valid), .average_ready(average_ready)
  );

  swm_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .sample(sample), .sample_valid(sample_valid), .sample_ready(sample_ready),
    .average(average), .average_valid(average_valid), .average_ready(average_ready),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (average_valid && average_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : drain_results
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        average_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      average_ready <= 1'b1;
      @(posedge clk);
      while (!average_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_window(input logic [APB_DATA_W-1:0] data);
    wait_drained();
    apb_access(1'b1, WINDOW_ADDR, data);
    apb_access(1'b0, WINDOW_ADDR, '0);
  endtask

  task automatic send_sample(input sample_t s);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return sample_t'(16'h7FFF);
    if (pick < 4) return sample_t'(16'h8000);
    if (pick < 6) return sample_t'(int'($urandom_range(0, 511)) - 256);
    return sample_t'($urandom());
  endfunction

  initial begin : stimulus
    logic [APB_DATA_W-1:0] win_plan [7];
    win_plan = '{32'd64, 32'd127, 32'd1, 32'd2, 32'd63, 32'd65, 32'd10};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    apb_access(1'b0, WINDOW_ADDR, '0);

    // The reset window of ten fills with the most negative sample, then wraps.
    repeat (11) send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h0000));
    send_sample(sample_t'(16'hFFFF));
    send_sample(sample_t'(16'h0001));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));

    // A zero window behaves as a window of one.
    set_window(32'd0);
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    // A write to an unused register must leave the window and history alone.
    wait_drained();
    apb_access(1'b1, SPARE_ADDR, 32'd5);
    send_sample(sample_t'(-3));

    // Only the low seven bits of the write data form the window.
    set_window(32'hFFFF_FF81);
    send_sample(sample_t'(16'h1234));
    send_sample(sample_t'(16'hEDCB));
    send_sample(sample_t'(16'h8000));

    for (int p = 0; p < PHASES; p++) begin
      if (p < 7) set_window(win_plan[p]);
      else set_window($urandom());
      gap_max = (p % 3 == 1) ? 0 : 9;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 8 && n == PHASE_ITEMS / 2) wait_drained();
        send_sample(random_sample());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
